### sv/vector_store_lru_cosine_match_unit_assert.svh
// Assertion helpers used by the block's top-level RTL file.
`ifndef VECTOR_STORE_LRU_COSINE_MATCH_UNIT_ASSERT_SVH
`define VECTOR_STORE_LRU_COSINE_MATCH_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define VSLCM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define VSLCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/vslcm_pkg.sv
`default_nettype none
package vslcm_pkg;
    localparam int SLOTS = 64;
    localparam int DIM   = 16;
    localparam int SW    = $clog2(SLOTS);
    localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int CW    = $clog2(DIM + 1);
    localparam int AW    = $clog2(SLOTS * DIM);
    localparam int VALW  = 16;
    localparam int AGEW  = 16;
    localparam int SLOTW = 7;
    localparam int SIMW  = 16;
    localparam int CMDW  = 2;

    // sums of squares, roots, divider
    localparam int SUMW  = 32 + $clog2(DIM);
    localparam int STEPS = (SUMW + 1) / 2;
    localparam int BW    = 2 * STEPS;
    localparam int RTW   = STEPS;
    localparam int DENW  = 2 * RTW;
    localparam int MOPW  = RTW + 1;
    localparam int PW    = 2 * MOPW;
    localparam int DOTW  = SUMW + 1;
    localparam int NUMW  = SUMW + 15;
    localparam int QB    = 17;
    localparam int DIVW  = DENW + QB + 1;

    localparam int IN_TDW  = 32;
    localparam int OUT_TDW = 40;

    localparam logic [AGEW-1:0]  AGE_MAX    = '1;
    localparam logic [SLOTW-1:0] SLOT_NONE  = '1;
    localparam logic [SIMW-1:0]  SIM_MIN    = 16'h8000;
    localparam logic [SIMW-1:0]  SIM_MAX    = 16'h7FFF;
    localparam logic [15:0]      THR_RESET  = 16'd58982;

    localparam logic [CMDW-1:0] CMD_BATCH  = 2'd0;
    localparam logic [CMDW-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMDW-1:0] CMD_QUERY  = 2'd2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_ELEM   = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_QN, ST_QSQ, ST_SCAN, ST_RD, ST_ACCD, ST_ACCC, ST_CSQ, ST_MUL,
        ST_DIVC, ST_DIV, ST_CMP, ST_ORD, ST_OWT, ST_LRU, ST_WR, ST_EMIT,
        ST_CLR, ST_AGE, ST_AGL, ST_LRE
    } t_state;
endpackage
`default_nettype wire

### sv/vslcm_ram.sv
`default_nettype none
module vslcm_ram #(
    parameter int W = 16,
    parameter int D = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### sv/vector_store_lru_cosine_match_unit.sv
// Channel  | Dir | Signals                          | Content
// ---------+-----+----------------------------------+-----------------------------------
// s stream | in  | tvalid tready tdata tuser tlast  | command, element, confidence, last
// m stream | out | tvalid tready tdata tuser tlast  | kind, slot, similarity, element, end
// cfg      | in  | valid ready data                 | threshold (Q0.16)
//
// Non-final elements are staged while idle; a batch start ages the slots.
// A final insert with confidence at or above the threshold scans the ages and writes DIM words.
// A final query takes the query norm and root, then for each valid slot the dot product, norm,
// root and quotient on the one shared multiplier, square-root and divide step unit, then emits DIM elements.
// Synchronous active-low reset, then the ages are cleared; ready only when idle.
// A waiting result holds the sequencer only when the next result is due.
`default_nettype none
`include "vector_store_lru_cosine_match_unit_assert.svh"
module vector_store_lru_cosine_match_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [vslcm_pkg::IN_TDW-1:0]    i_s_tdata,  // value[15:0], confidence[31:16]
    input  wire logic [vslcm_pkg::CMDW-1:0]      i_s_tuser,  // cmd[1:0]
    input  wire logic                            i_s_tlast,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic      [vslcm_pkg::OUT_TDW-1:0]   o_m_tdata,  // slot[6:0], similarity[22:7],
                                                             // element[38:23], zero[39]
    output logic      [0:0]                      o_m_tuser,  // kind[0]
    output logic                                 o_m_tlast,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [15:0]                     i_cfg_data
);
    import vslcm_pkg::*;

    t_state r_state, n_state;

    logic [15:0]      r_thr;
    logic [CW-1:0]    r_cnt, r_vlen, r_i;
    logic [VALW-1:0]  r_stg [DIM];
    logic [SLOTS-1:0] r_valid;
    logic [SW-1:0]    r_s, r_bidx, r_ls;
    logic             r_lv;
    logic [AGEW-1:0]  r_bage;
    logic             r_bfound;
    logic [SIMW-1:0]  r_bsim;
    logic [SUMW-1:0]  r_qn, r_cn;
    logic [DOTW-1:0]  r_dot;
    logic [BW-1:0]    r_sx, r_sr, r_sbit;
    logic [RTW-1:0]   r_qroot, r_croot;
    logic [5:0]       r_k;
    logic [DENW-1:0]  r_den;
    logic [DIVW-1:0]  r_rem, r_dsh;
    logic [QB-1:0]    r_q;
    logic             r_neg, r_ovf;

    logic             r_ovalid, r_okind, r_olast;
    logic [SLOTW-1:0] r_oslot;
    logic [SIMW-1:0]  r_osim;
    logic [VALW-1:0]  r_oelem;

    logic             w_in_acc, w_ofree, w_ilast, w_oload;
    logic [CMDW-1:0]  w_cmd;
    logic [VALW-1:0]  w_val, w_conf, w_stg, w_rdata;
    logic [MOPW-1:0]  w_ma, w_mb;
    logic [PW-1:0]    w_prod;
    logic [SUMW-1:0]  w_sq;
    logic [BW-1:0]    w_ssum, w_sx_n, w_sr_n;
    logic             w_sge;
    logic [SUMW-1:0]  w_mag;
    logic [SIMW-1:0]  w_sim;
    logic             w_we, w_re;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic             w_age_we, w_age_re;
    logic [SW-1:0]    w_age_waddr, w_age_raddr;
    logic [AGEW-1:0]  w_age_wdata, w_age_rdata;

    assign w_cmd    = i_s_tuser;
    assign w_val    = i_s_tdata[15:0];
    assign w_conf   = i_s_tdata[31:16];
    assign w_in_acc = i_s_tvalid && o_s_tready;
    assign w_ofree  = !r_ovalid || i_m_tready;
    assign w_ilast  = (r_i == CW'(DIM - 1));
    assign w_oload  = ((r_state == ST_OWT) || (r_state == ST_EMIT)) && w_ofree;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = {1'b0, r_oelem, r_osim, r_oslot};
    assign o_m_tuser   = r_okind;
    assign o_m_tlast   = r_olast;

    // staged element, zero past a short vector
    assign w_stg = (r_i < r_vlen) ? r_stg[r_i[IW-1:0]] : '0;

    // shared multiplier: squares, dot terms and the root product
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            ST_QN: begin
                w_ma = MOPW'($signed(w_stg));
                w_mb = MOPW'($signed(w_stg));
            end
            ST_ACCD: begin
                w_ma = MOPW'($signed(w_stg));
                w_mb = MOPW'($signed(w_rdata));
            end
            ST_ACCC: begin
                w_ma = MOPW'($signed(w_rdata));
                w_mb = MOPW'($signed(w_rdata));
            end
            ST_MUL: begin
                w_ma = {1'b0, r_qroot};
                w_mb = {1'b0, r_croot};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_prod = PW'($signed(w_ma) * $signed(w_mb));
    assign w_sq   = w_prod[SUMW-1:0];

    // shared square-root step: each pass consumes two radicand bits
    assign w_ssum = r_sr + r_sbit;
    assign w_sge  = (r_sx >= w_ssum);
    assign w_sx_n = w_sge ? (r_sx - w_ssum) : r_sx;
    assign w_sr_n = w_sge ? ((r_sr >> 1) + r_sbit) : (r_sr >> 1);

    assign w_mag = r_dot[DOTW-1] ? SUMW'(-r_dot) : SUMW'(r_dot);

    // saturate the quotient into Q1.15
    always_comb begin
        if (!r_neg) begin
            w_sim = (r_ovf || r_q > QB'(32767)) ? SIM_MAX : r_q[SIMW-1:0];
        end else begin
            w_sim = (r_ovf || r_q > QB'(32768)) ? SIM_MIN : SIMW'(QB'(0) - r_q);
        end
    end

    assign w_we    = (r_state == ST_WR);
    assign w_waddr = AW'(AW'(r_bidx) * AW'(DIM) + AW'(r_i));
    assign w_re    = (r_state == ST_RD) || (r_state == ST_ORD);
    assign w_raddr = AW'(AW'((r_state == ST_ORD) ? r_bidx : r_s) * AW'(DIM) + AW'(r_i));

    vslcm_ram #(.W(VALW), .D(SLOTS * DIM)) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_stg),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // age RAM: clear after reset, read-modify-write on a batch start, zero on a store
    always_comb begin
        w_age_we    = 1'b0;
        w_age_waddr = r_ls;
        w_age_wdata = '0;
        unique case (r_state)
            ST_CLR: begin
                w_age_we    = 1'b1;
                w_age_waddr = r_s;
            end
            ST_AGE, ST_AGL: begin
                w_age_we    = (r_state == ST_AGL) || r_lv;
                w_age_wdata = (w_age_rdata == AGE_MAX) ? AGE_MAX : w_age_rdata + 1'b1;
            end
            ST_WR: begin
                w_age_we    = w_ilast;
                w_age_waddr = r_bidx;
            end
            default: begin
            end
        endcase
    end
    assign w_age_re    = (r_state == ST_AGE) || (r_state == ST_LRU);
    assign w_age_raddr = r_s;

    vslcm_ram #(.W(AGEW), .D(SLOTS)) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (w_age_we),
        .i_waddr (w_age_waddr),
        .i_wdata (w_age_wdata),
        .i_re    (w_age_re),
        .i_raddr (w_age_raddr),
        .o_rdata (w_age_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && w_cmd == CMD_BATCH) begin
                    n_state = ST_AGE;
                end else if (w_in_acc && i_s_tlast &&
                    (w_cmd == CMD_INSERT || w_cmd == CMD_QUERY)) begin
                    if (w_cmd == CMD_QUERY) begin
                        n_state = ST_QN;
                    end else if (w_conf < r_thr) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_LRU;
                    end
                end
            end
            ST_QN:   if (w_ilast) n_state = ST_QSQ;
            ST_QSQ:  if (r_k == 6'(STEPS - 1)) n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_valid[r_s]) begin
                    n_state = ST_RD;
                end else if (r_s == SW'(SLOTS - 1)) begin
                    n_state = ST_ORD;
                end
            end
            ST_RD:   n_state = ST_ACCD;
            ST_ACCD: n_state = ST_ACCC;
            ST_ACCC: n_state = w_ilast ? ST_CSQ : ST_RD;
            ST_CSQ:  if (r_k == 6'(STEPS - 1)) n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIVC;
            ST_DIVC: n_state = ST_DIV;
            ST_DIV:  if (r_k == 6'(QB - 1)) n_state = ST_CMP;
            ST_CMP:  n_state = (r_s == SW'(SLOTS - 1)) ? ST_ORD : ST_SCAN;
            ST_ORD:  n_state = ST_OWT;
            ST_OWT:  if (w_ofree) n_state = w_ilast ? ST_IDLE : ST_ORD;
            ST_LRU:  if (r_s == SW'(SLOTS - 1)) n_state = ST_LRE;
            ST_LRE:  n_state = ST_WR;
            ST_WR:   if (w_ilast) n_state = ST_EMIT;
            ST_EMIT: if (w_ofree) n_state = ST_IDLE;
            ST_CLR:  if (r_s == SW'(SLOTS - 1)) n_state = ST_IDLE;
            ST_AGE:  if (r_s == SW'(SLOTS - 1)) n_state = ST_AGL;
            ST_AGL:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= THR_RESET;
            r_cnt    <= '0;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
            r_s      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (r_ovalid && i_m_tready && !w_oload) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && w_cmd == CMD_BATCH) begin
                        // start the ageing pass at slot zero
                        r_s  <= '0;
                        r_lv <= 1'b0;
                    end else if (w_in_acc && (w_cmd == CMD_INSERT || w_cmd == CMD_QUERY)) begin
                        if (r_cnt < CW'(DIM)) begin
                            r_stg[r_cnt[IW-1:0]] <= w_val;
                        end
                        if (i_s_tlast) begin
                            r_cnt    <= '0;
                            r_vlen   <= (r_cnt < CW'(DIM)) ? r_cnt + 1'b1 : CW'(DIM);
                            r_i      <= '0;
                            r_qn     <= '0;
                            r_s      <= '0;
                            r_lv     <= 1'b0;
                            r_bidx   <= '0;
                            r_bage   <= '0;
                            r_bfound <= 1'b0;
                        end else if (r_cnt < CW'(DIM)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                ST_QN: begin
                    r_qn <= r_qn + w_sq;
                    r_i  <= r_i + 1'b1;
                    if (w_ilast) begin
                        r_sx   <= BW'(r_qn + w_sq) + 1'b1;
                        r_sr   <= '0;
                        r_sbit <= BW'(1) << (BW - 2);
                        r_k    <= '0;
                    end
                end
                ST_QSQ: begin
                    r_sx   <= w_sx_n;
                    r_sr   <= w_sr_n;
                    r_sbit <= r_sbit >> 2;
                    r_k    <= r_k + 1'b1;
                    if (r_k == 6'(STEPS - 1)) begin
                        r_qroot  <= w_sr_n[RTW-1:0];
                        r_s      <= '0;
                        r_bsim   <= SIM_MIN;
                        r_bfound <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    r_i   <= '0;
                    r_dot <= '0;
                    r_cn  <= '0;
                    // skip empty slots
                    if (!r_valid[r_s] && r_s != SW'(SLOTS - 1)) begin
                        r_s <= r_s + 1'b1;
                    end
                end
                ST_RD: begin
                end
                ST_ACCD: begin
                    r_dot <= r_dot + DOTW'(w_prod);
                end
                ST_ACCC: begin
                    r_cn <= r_cn + w_sq;
                    r_i  <= r_i + 1'b1;
                    if (w_ilast) begin
                        r_sx   <= BW'(r_cn + w_sq) + 1'b1;
                        r_sr   <= '0;
                        r_sbit <= BW'(1) << (BW - 2);
                        r_k    <= '0;
                    end
                end
                ST_CSQ: begin
                    r_sx   <= w_sx_n;
                    r_sr   <= w_sr_n;
                    r_sbit <= r_sbit >> 2;
                    r_k    <= r_k + 1'b1;
                    if (r_k == 6'(STEPS - 1)) begin
                        r_croot <= w_sr_n[RTW-1:0];
                    end
                end
                ST_MUL: begin
                    r_den <= (w_prod[DENW-1:0] == '0) ? DENW'(1) : w_prod[DENW-1:0];
                    r_rem <= DIVW'({w_mag, 15'b0});
                    r_neg <= r_dot[DOTW-1];
                end
                ST_DIVC: begin
                    r_ovf <= (r_rem >= (DIVW'(r_den) << QB));
                    r_dsh <= DIVW'(r_den) << (QB - 1);
                    r_q   <= '0;
                    r_k   <= '0;
                end
                ST_DIV: begin
                    if (r_rem >= r_dsh) begin
                        r_rem <= r_rem - r_dsh;
                    end
                    r_q   <= {r_q[QB-2:0], (r_rem >= r_dsh)};
                    r_dsh <= r_dsh >> 1;
                    r_k   <= r_k + 1'b1;
                end
                ST_CMP: begin
                    // strictly greater replaces the running best
                    if ($signed(w_sim) > $signed(r_bsim)) begin
                        r_bsim   <= w_sim;
                        r_bidx   <= r_s;
                        r_bfound <= 1'b1;
                    end
                    if (r_s == SW'(SLOTS - 1)) begin
                        r_i <= '0;
                    end else begin
                        r_s <= r_s + 1'b1;
                    end
                end
                ST_ORD: begin
                end
                ST_OWT: begin
                    if (w_ofree) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_ELEM;
                        r_oslot  <= r_bfound ? SLOTW'(r_bidx) : SLOT_NONE;
                        r_osim   <= r_bsim;
                        r_oelem  <= r_bfound ? w_rdata : '0;
                        r_olast  <= w_ilast;
                        r_i      <= r_i + 1'b1;
                    end
                end
                ST_LRU: begin
                    // compare the age read last cycle, issue the next read
                    if (r_lv && w_age_rdata > r_bage) begin
                        r_bage <= w_age_rdata;
                        r_bidx <= r_ls;
                    end
                    r_ls <= r_s;
                    r_lv <= 1'b1;
                    if (r_s != SW'(SLOTS - 1)) begin
                        r_s <= r_s + 1'b1;
                    end
                    r_i <= '0;
                end
                ST_LRE: begin
                    if (w_age_rdata > r_bage) begin
                        r_bage <= w_age_rdata;
                        r_bidx <= r_ls;
                    end
                    r_i <= '0;
                end
                ST_WR: begin
                    r_i <= r_i + 1'b1;
                    if (w_ilast) begin
                        r_valid[r_bidx] <= 1'b1;
                        r_bfound        <= 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (w_ofree) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_INSERT;
                        r_oslot  <= r_bfound ? SLOTW'(r_bidx) : SLOT_NONE;
                        r_osim   <= '0;
                        r_oelem  <= '0;
                        r_olast  <= 1'b1;
                    end
                end
                ST_CLR: begin
                    if (r_s != SW'(SLOTS - 1)) begin
                        r_s <= r_s + 1'b1;
                    end
                end
                ST_AGE: begin
                    // write back the slot read last cycle, read the next one
                    r_ls <= r_s;
                    r_lv <= 1'b1;
                    if (r_s != SW'(SLOTS - 1)) begin
                        r_s <= r_s + 1'b1;
                    end
                end
                ST_AGL: begin
                end
                default: begin
                end
            endcase
        end
    end

    `VSLCM_ASSERT_SAME(a_cnt_range, 1'b1, r_cnt <= CW'(DIM), "staging count beyond vector length")
    `VSLCM_ASSERT_SAME(a_nomatch_zero, r_ovalid && r_okind == KIND_ELEM && r_oslot == SLOT_NONE, r_oelem == '0, "element of a missed query is not zero")
    `VSLCM_ASSERT_NEXT(a_insert_valid, r_state == ST_WR && w_ilast, r_valid[r_bidx] && r_state == ST_EMIT, "stored slot not marked valid")
    `VSLCM_ASSERT_SAME(a_insert_end, r_ovalid && r_okind == KIND_INSERT, r_olast, "insert outcome without end of run")
endmodule
`default_nettype wire
